>>> rtl/core/css_pkg.sv
// Shared types and constants of the clocked step sequencer.
`default_nettype none

package css_pkg;

    // Steps in the pattern by default, and pads on the surface.
    localparam int NUM_STEPS_DEF   = 24;
    localparam int PAD_COUNT       = 24;
    // Clock pulses per sixteenth note.
    localparam int PULSES_PER_STEP = 6;
    localparam logic [6:0] VELOCITY_RESET = 7'd100;
    // Entries in the queue between the front and the back part.
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_ENTER = 2'd1;
    localparam logic [1:0] CMD_LEAVE = 2'd2;

    localparam logic EV_NOTE_OFF = 1'b0;
    localparam logic EV_NOTE_ON  = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SCAN,
        OP_ENTER,
        OP_LEAVE
    } t_op;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_DIVFIX,
        B_MOD,
        B_MODFIX,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] touched_map;
        logic        start_seen;
        logic        running;
        logic [31:0] clock_pulses;
    } t_in_word;

    typedef struct packed {
        logic        event_kind;
        logic [4:0]  pad;
        logic [6:0]  velocity;
        logic [4:0]  current_step;
        logic [23:0] armed_map;
        logic        last;
    } t_out_word;

    // A classified word as it waits in the queue.
    typedef struct packed {
        t_op         op;
        logic [23:0] touched;
        logic        start;
        logic        running;
        logic [31:0] pulse;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qhead;

endpackage

`default_nettype wire

>>> rtl/core/css_front.sv
// Front part: accepts input words, classifies the command and queues the job.
`default_nettype none

module css_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire css_pkg::t_in_word i_in,
    output css_pkg::t_qhead       o_head,
    input  wire logic             i_pop
);

    localparam int Depth = css_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    css_pkg::t_job r_q [Depth];
    logic [PtrW-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            push;
    logic            pop;
    css_pkg::t_job   job;

    always_comb begin
        job.touched = i_in.touched_map;
        job.start   = i_in.start_seen;
        job.running = i_in.running;
        job.pulse   = i_in.clock_pulses;
        case (i_in.cmd)
            css_pkg::CMD_SCAN:  job.op = css_pkg::OP_SCAN;
            css_pkg::CMD_ENTER: job.op = css_pkg::OP_ENTER;
            css_pkg::CMD_LEAVE: job.op = css_pkg::OP_LEAVE;
            default:            job.op = css_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall = (r_cnt == CntW'(Depth));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_q[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == PtrW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == PtrW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/css_back.sv
// Back part: sequencer state, step advance arithmetic and the output register.
`default_nettype none

module css_back #(
    parameter int NUM_STEPS = css_pkg::NUM_STEPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire css_pkg::t_qhead   i_head,
    output logic                   o_pop,
    input  wire logic              i_cfg_we,
    input  wire logic [6:0]        i_cfg_wdata,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output css_pkg::t_out_word     o_out
);

    localparam int PW       = (NUM_STEPS > 2) ? $clog2(NUM_STEPS) : 1;
    localparam int PadSteps = (NUM_STEPS < css_pkg::PAD_COUNT) ? NUM_STEPS : css_pkg::PAD_COUNT;
    localparam logic [23:0] StepMask = 24'((25'(1) << PadSteps) - 25'(1));
    localparam logic [31:0] DivMagic = 32'((64'd1 << 32) / css_pkg::PULSES_PER_STEP);
    localparam logic [31:0] ModMagic = 32'((64'd1 << 32) / NUM_STEPS);
    localparam logic [3:0]  Pps4     = 4'(css_pkg::PULSES_PER_STEP);
    localparam logic [7:0]  Steps8   = 8'(NUM_STEPS);

    css_pkg::t_bstate r_state, n_state;
    logic             r_active, n_active;
    logic             r_sounding, n_sounding;
    logic [4:0]       r_spad, n_spad;
    logic [23:0]      r_armed, n_armed;
    logic [23:0]      r_prev, n_prev;
    logic [PW-1:0]    r_play, n_play;
    logic [31:0]      r_sstart, n_sstart;
    logic             r_off_v, n_off_v;
    logic [4:0]       r_off_pad, n_off_pad;
    logic             r_on_v, n_on_v;
    logic [4:0]       r_on_pad, n_on_pad;
    logic [6:0]       r_velocity;
    logic             r_out_valid, n_out_valid;
    css_pkg::t_out_word r_out, n_out;

    logic [31:0]      r_elapsed, n_elapsed;
    logic [63:0]      r_prod, n_prod;
    logic [29:0]      r_k, n_k;
    logic [30:0]      r_sum, n_sum;

    css_pkg::t_job    job;
    logic [23:0]      armed_scan;
    logic [31:0]      elapsed;
    logic [3:0]       rem4;
    logic [7:0]       rem8;
    logic [30:0]      sum;
    logic             go_en;
    logic [PW-1:0]    go_step;
    logic [5:0]       step6;
    logic [23:0]      go_armed;
    logic             hit;
    logic             end_en;
    logic             out_free;

    assign job        = i_head.job;
    assign armed_scan = r_armed ^ (job.touched & ~r_prev & StepMask);
    assign elapsed    = job.pulse - r_sstart;
    assign out_free   = !r_out_valid || !i_out_stall;
    // The estimate from the reciprocal is at most one low, so the remainders stay small.
    assign rem4       = r_elapsed[3:0] - 4'(r_prod[35:32] * Pps4);
    assign rem8       = r_sum[7:0] - 8'(r_prod[39:32] * Steps8);
    assign sum        = 31'(r_k) + 31'(r_play);
    assign step6      = 6'(go_step);
    assign go_armed   = (r_state == css_pkg::B_IDLE) ? armed_scan : r_armed;
    assign hit        = (step6 < 6'(css_pkg::PAD_COUNT)) && go_armed[step6[4:0]];

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_sounding  = r_sounding;
        n_spad      = r_spad;
        n_armed     = r_armed;
        n_prev      = r_prev;
        n_play      = r_play;
        n_sstart    = r_sstart;
        n_off_v     = r_off_v;
        n_off_pad   = r_off_pad;
        n_on_v      = r_on_v;
        n_on_pad    = r_on_pad;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_k         = r_k;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        go_en       = 1'b0;
        go_step     = '0;
        end_en      = 1'b0;

        case (r_state)
            css_pkg::B_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (job.op)
                        css_pkg::OP_ENTER: begin
                            end_en   = 1'b1;
                            n_active = 1'b1;
                            n_play   = '0;
                            n_sstart = '0;
                            n_prev   = job.touched;
                        end
                        css_pkg::OP_LEAVE: begin
                            if (r_active) begin
                                end_en   = 1'b1;
                                n_active = 1'b0;
                            end
                        end
                        css_pkg::OP_SCAN: begin
                            if (r_active) begin
                                n_armed = armed_scan;
                                n_prev  = job.touched;
                                if (job.start) begin
                                    n_sstart = job.pulse;
                                    go_en    = 1'b1;
                                end else if (!job.running) begin
                                    end_en = 1'b1;
                                end else if (elapsed >= 32'(css_pkg::PULSES_PER_STEP)) begin
                                    n_elapsed = elapsed;
                                    n_state   = css_pkg::B_DIV;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            css_pkg::B_DIV: begin
                n_prod  = 64'(r_elapsed) * 64'(DivMagic);
                n_state = css_pkg::B_DIVFIX;
            end
            css_pkg::B_DIVFIX: begin
                n_k     = r_prod[61:32] + 30'(rem4 >= Pps4);
                n_state = css_pkg::B_MOD;
            end
            css_pkg::B_MOD: begin
                n_sum    = sum;
                n_prod   = 64'(sum) * 64'(ModMagic);
                n_sstart = r_sstart + 32'({r_k, 2'b00}) + 32'({r_k, 1'b0});
                n_state  = css_pkg::B_MODFIX;
            end
            css_pkg::B_MODFIX: begin
                go_en   = 1'b1;
                go_step = (rem8 >= Steps8) ? PW'(rem8 - Steps8) : PW'(rem8);
            end
            css_pkg::B_EMIT: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out.current_step     = 5'(r_play);
                    n_out.armed_map        = r_armed;
                    if (r_off_v) begin
                        n_out.event_kind   = css_pkg::EV_NOTE_OFF;
                        n_out.pad          = r_off_pad;
                        n_out.velocity     = '0;
                        n_out.last         = !r_on_v;
                        n_off_v            = 1'b0;
                        if (!r_on_v) begin
                            n_state = css_pkg::B_IDLE;
                        end
                    end else begin
                        n_out.event_kind   = css_pkg::EV_NOTE_ON;
                        n_out.pad          = r_on_pad;
                        n_out.velocity     = r_velocity;
                        n_out.last         = 1'b1;
                        n_on_v             = 1'b0;
                        n_state            = css_pkg::B_IDLE;
                    end
                end
            end
            default: begin
                n_state = css_pkg::B_IDLE;
            end
        endcase

        // Ending the sounding note, alone or before a move of the playhead.
        if (end_en || go_en) begin
            n_off_v    = r_sounding;
            n_off_pad  = r_spad;
            n_on_v     = 1'b0;
            n_sounding = 1'b0;
            n_state    = r_sounding ? css_pkg::B_EMIT : css_pkg::B_IDLE;
        end
        if (go_en) begin
            n_play = go_step;
            if (hit) begin
                n_on_v     = 1'b1;
                n_on_pad   = step6[4:0] + 5'd1;
                n_spad     = step6[4:0] + 5'd1;
                n_sounding = 1'b1;
                n_state    = css_pkg::B_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= css_pkg::B_IDLE;
            r_active    <= 1'b0;
            r_sounding  <= 1'b0;
            r_spad      <= '0;
            r_armed     <= '0;
            r_prev      <= '0;
            r_play      <= '0;
            r_sstart    <= '0;
            r_off_v     <= 1'b0;
            r_on_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_velocity  <= css_pkg::VELOCITY_RESET;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_sounding  <= n_sounding;
            r_spad      <= n_spad;
            r_armed     <= n_armed;
            r_prev      <= n_prev;
            r_play      <= n_play;
            r_sstart    <= n_sstart;
            r_off_v     <= n_off_v;
            r_on_v      <= n_on_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_velocity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_pad <= n_off_pad;
        r_on_pad  <= n_on_pad;
        r_elapsed <= n_elapsed;
        r_prod    <= n_prod;
        r_k       <= n_k;
        r_sum     <= n_sum;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> rtl/core/clocked_step_sequencer_top.sv
// Top level of the clocked step sequencer: front queue, back part and checks.
//
//  channel   direction  handshake                        payload
//  input     in         i_in_valid / o_in_stall          i_in  (css_pkg::t_in_word)
//  output    out        o_out_valid / i_out_stall        o_out (css_pkg::t_out_word)
//  config    in         i_cfg_we                         i_cfg_wdata (note velocity)
//
// Each event of a word (at most two) is emitted from state B_EMIT; a scan that
// advances the playhead first passes B_DIV, B_DIVFIX, B_MOD and B_MODFIX for
// the divide by six and the modulo, each a registered reciprocal multiply.
// A two-word queue lets the front keep accepting while the back part works.
// Reset is synchronous and active low; it disarms all steps and leaves
// sequencer mode. A stalled output holds its word while the back part waits.
`default_nettype none

module clocked_step_sequencer_top #(
    parameter int NUM_STEPS = css_pkg::NUM_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire css_pkg::t_in_word  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output css_pkg::t_out_word      o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [6:0]         i_cfg_wdata
);

    css_pkg::t_qhead head;
    logic            pop;

    css_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_head     (head),
        .i_pop      (pop)
    );

    css_back #(
        .NUM_STEPS (NUM_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Only a note-off can be followed by another event of the same word.
    a_first_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_out.event_kind == css_pkg::EV_NOTE_OFF)
        else $error("non-final event is not a note-off");

    a_off_no_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.event_kind == css_pkg::EV_NOTE_OFF |-> o_out.velocity == 7'd0)
        else $error("note-off carries a velocity");

    a_pad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.pad != 5'd0 && o_out.pad <= 5'(css_pkg::PAD_COUNT))
        else $error("event pad out of range");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && NUM_STEPS <= 32 |-> 7'(o_out.current_step) < 7'(NUM_STEPS))
        else $error("playhead beyond the last step");

endmodule

`default_nettype wire
